>>> design/decimal_schoolbook_multiplier_unit_macros.svh
// ----------------------------------------------------------------------------
// Decimal schoolbook multiplier assertion macros
// Short forms for the concurrent checks used in the unit. Each macro expects
// clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_SCHOOLBOOK_MULTIPLIER_UNIT_MACROS_SVH
`define DECIMAL_SCHOOLBOOK_MULTIPLIER_UNIT_MACROS_SVH

// condition that must hold at every edge out of reset
`define DSM_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define DSM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DSM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types and constants of the decimal schoolbook multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsm_pkg;

	// default operand capacity in digits
	localparam int MAX_DIGITS_DEF = 32;

	localparam int DIGIT_W = 4;
	// 9 * 9 = 81 fits in 7 bits
	localparam int PROD_W = 7;
	// column sum plus incoming carry stays below 2900
	localparam int ACC_W = 12;

	// divide by ten: (x * 0xCCCD) >> 19 is exact for 16-bit x
	localparam int RECIP_W = 16;
	localparam logic [RECIP_W-1:0] RECIP_10 = 16'hCCCD;
	localparam int RECIP_SHIFT = 19;

	localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	// operand selector carried in tuser
	typedef enum logic {
		OP_FIRST  = 1'b0,
		OP_SECOND = 1'b1
	} dsm_op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_COL_INIT,
		ST_MAC,
		ST_DRAIN,
		ST_SPLIT,
		ST_EMIT_RD,
		ST_EMIT_WAIT,
		ST_EMIT_HOLD
	} dsm_state_t;

	// strobes from the sequencer to the datapath
	typedef struct packed {
		logic load_ready;
		logic acc_clr;
		logic issue;
		logic split;
		logic res_rd;
		logic out_load;
		logic out_valid;
		logic clear;
	} dsm_ctrl_t;

	// digits above nine saturate
	function automatic logic [DIGIT_W-1:0] digit_sat(input logic [DIGIT_W-1:0] d);
		return (d > DIGIT_MAX) ? DIGIT_MAX : d;
	endfunction

endpackage

>>> design/dsm_digit_mem.sv
// ----------------------------------------------------------------------------
// dsm_digit_mem
// Single-write, single-read digit memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsm_digit_mem #(
	parameter int DEPTH = dsm_pkg::MAX_DIGITS_DEF,
	parameter int AW = 5
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [dsm_pkg::DIGIT_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [dsm_pkg::DIGIT_W-1:0] rdata
);

	logic [dsm_pkg::DIGIT_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/dsm_mac.sv
// ----------------------------------------------------------------------------
// dsm_mac
// Shared column unit: one digit product per cycle into an accumulator, and a
// split of the accumulator into product digit and carry by a reciprocal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsm_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dsm_pkg::dsm_ctrl_t          ctrl,
	input  logic [dsm_pkg::DIGIT_W-1:0] a_digit,
	input  logic [dsm_pkg::DIGIT_W-1:0] b_digit,
	output logic                        carry_nz,
	output logic                        pipe_busy,
	output logic [dsm_pkg::DIGIT_W-1:0] rem_digit
);

	localparam int MW = dsm_pkg::ACC_W + dsm_pkg::RECIP_W;

	logic                        rd_vld_s1;
	logic                        prod_vld_s2;
	logic [dsm_pkg::PROD_W-1:0]  prod_s2;
	logic [dsm_pkg::ACC_W-1:0]   acc_q;
	logic [MW-1:0]               recip_prod;
	logic [dsm_pkg::ACC_W-1:0]   quot;
	logic [dsm_pkg::ACC_W-1:0]   quot_x10;
	logic [dsm_pkg::ACC_W-1:0]   rem_full;

	// read data arrives in the cycle after issue; product registered after that
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			prod_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1   <= ctrl.issue;
			prod_vld_s2 <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			prod_s2 <= dsm_pkg::PROD_W'(a_digit) * dsm_pkg::PROD_W'(b_digit);
		end
	end

	// quotient and remainder by ten
	always_comb begin
		recip_prod = MW'(acc_q) * MW'(dsm_pkg::RECIP_10);
		quot       = dsm_pkg::ACC_W'(recip_prod >> dsm_pkg::RECIP_SHIFT);
		quot_x10   = dsm_pkg::ACC_W'(quot * dsm_pkg::ACC_W'(dsm_pkg::DEC_BASE));
		rem_full   = acc_q - quot_x10;
	end

	// accumulator: cleared per product, keeps the carry across columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			priority if (ctrl.acc_clr) begin
				acc_q <= '0;
			end else if (ctrl.split) begin
				acc_q <= quot;
			end else if (prod_vld_s2) begin
				acc_q <= acc_q + dsm_pkg::ACC_W'(prod_s2);
			end
		end
	end

	assign rem_digit = rem_full[dsm_pkg::DIGIT_W-1:0];
	assign carry_nz  = (acc_q != '0);
	assign pipe_busy = rd_vld_s1 | prod_vld_s2;

endmodule

>>> design/dsm_seq.sv
// ----------------------------------------------------------------------------
// dsm_seq
// Sequencer: walks columns from least significant up, issues the digit pairs
// of each column, splits off digits, then reads the product back MSD first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_schoolbook_multiplier_unit_macros.svh"

module dsm_seq #(
	parameter int MAX_DIGITS = dsm_pkg::MAX_DIGITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [$clog2(MAX_DIGITS+1)-1:0]        len_a,
	input  logic [$clog2(MAX_DIGITS+1)-1:0]        len_b,
	input  logic                                   carry_nz,
	input  logic                                   pipe_busy,
	input  logic                                   out_ready,
	output dsm_pkg::dsm_ctrl_t                     ctrl,
	output logic [((MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1)-1:0] a_raddr,
	output logic [((MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1)-1:0] b_raddr,
	output logic [$clog2(2*MAX_DIGITS)-1:0]        res_waddr,
	output logic [$clog2(2*MAX_DIGITS)-1:0]        res_raddr,
	output logic                                   out_last
);

	localparam int LW   = $clog2(MAX_DIGITS + 1);
	localparam int AW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int COLS = 2 * MAX_DIGITS;
	localparam int CW   = $clog2(COLS + 1);
	localparam int RW   = $clog2(COLS);

	dsm_pkg::dsm_state_t state_q, state_d;

	logic [CW-1:0] col_q;
	logic [LW-1:0] i_q;
	logic [LW-1:0] hi_q;
	logic [RW-1:0] ptr_q;

	logic [CW-1:0] la_m1, lb_m1, nbase;
	logic [CW-1:0] lo_c, hi_c, b_idx;
	logic          col_lt_base, col_lt_cols, ptr_zero;

	// column bounds: first-operand index i runs lo..hi, counted from LSD
	always_comb begin
		la_m1       = CW'(len_a) - CW'(1);
		lb_m1       = CW'(len_b) - CW'(1);
		nbase       = CW'(len_a) + lb_m1;
		lo_c        = (col_q > lb_m1) ? (col_q - lb_m1) : '0;
		hi_c        = (col_q < la_m1) ? col_q : la_m1;
		b_idx       = lb_m1 - (col_q - CW'(i_q));
		col_lt_base = (col_q < nbase);
		col_lt_cols = (col_q < CW'(COLS));
		ptr_zero    = (ptr_q == '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dsm_pkg::ST_LOAD: begin
				if (start) state_d = dsm_pkg::ST_COL_INIT;
			end
			dsm_pkg::ST_COL_INIT: begin
				priority if (col_lt_base) state_d = dsm_pkg::ST_MAC;
				else if (carry_nz && col_lt_cols) state_d = dsm_pkg::ST_SPLIT;
				else state_d = dsm_pkg::ST_EMIT_RD;
			end
			dsm_pkg::ST_MAC: begin
				if (i_q == hi_q) state_d = dsm_pkg::ST_DRAIN;
			end
			dsm_pkg::ST_DRAIN: begin
				if (!pipe_busy) state_d = dsm_pkg::ST_SPLIT;
			end
			dsm_pkg::ST_SPLIT: begin
				state_d = dsm_pkg::ST_COL_INIT;
			end
			dsm_pkg::ST_EMIT_RD: begin
				state_d = dsm_pkg::ST_EMIT_WAIT;
			end
			dsm_pkg::ST_EMIT_WAIT: begin
				state_d = dsm_pkg::ST_EMIT_HOLD;
			end
			dsm_pkg::ST_EMIT_HOLD: begin
				if (out_ready) state_d = ptr_zero ? dsm_pkg::ST_LOAD : dsm_pkg::ST_EMIT_RD;
			end
			default: begin
				state_d = dsm_pkg::ST_LOAD;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctrl            = '0;
		ctrl.load_ready = (state_q == dsm_pkg::ST_LOAD);
		ctrl.acc_clr    = (state_q == dsm_pkg::ST_LOAD) && start;
		ctrl.issue      = (state_q == dsm_pkg::ST_MAC);
		ctrl.split      = (state_q == dsm_pkg::ST_SPLIT);
		ctrl.res_rd     = (state_q == dsm_pkg::ST_EMIT_RD);
		ctrl.out_load   = (state_q == dsm_pkg::ST_EMIT_WAIT);
		ctrl.out_valid  = (state_q == dsm_pkg::ST_EMIT_HOLD);
		ctrl.clear      = (state_q == dsm_pkg::ST_EMIT_HOLD) && out_ready && ptr_zero;
		a_raddr         = AW'(len_a - LW'(1) - i_q);
		b_raddr         = b_idx[AW-1:0];
		res_waddr       = col_q[RW-1:0];
		res_raddr       = ptr_q;
		out_last        = ptr_zero;
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsm_pkg::ST_LOAD;
			col_q   <= '0;
			i_q     <= '0;
			hi_q    <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				dsm_pkg::ST_LOAD: begin
					col_q <= '0;
				end
				dsm_pkg::ST_COL_INIT: begin
					i_q   <= lo_c[LW-1:0];
					hi_q  <= hi_c[LW-1:0];
					ptr_q <= RW'(col_q - CW'(1));
				end
				dsm_pkg::ST_MAC: begin
					i_q <= i_q + LW'(1);
				end
				dsm_pkg::ST_SPLIT: begin
					col_q <= col_q + CW'(1);
				end
				dsm_pkg::ST_EMIT_HOLD: begin
					if (out_ready && !ptr_zero) ptr_q <= ptr_q - RW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// digit index never passes the column bound while pairs are issued
	`DSM_ASSERT_IMP(a_mac_index, state_q == dsm_pkg::ST_MAC, i_q <= hi_q && col_lt_base, "column index out of range")
	// a split must see the finished column and a slot in the result store
	`DSM_ASSERT_IMP(a_split_ready, state_q == dsm_pkg::ST_SPLIT, !pipe_busy && col_lt_cols, "split while busy or beyond store")
	// a new product starts only from the load phase
	`DSM_ASSERT_IMP(a_start_idle, start, state_q == dsm_pkg::ST_LOAD, "start outside load phase")
	// the last digit handed out leaves the block ready for new operands
	`DSM_ASSERT_NXT(a_clear_load, ctrl.clear, state_q == dsm_pkg::ST_LOAD, "no return to load after product")

endmodule

>>> design/decimal_schoolbook_multiplier_unit.sv
// ----------------------------------------------------------------------------
// decimal_schoolbook_multiplier_unit
// Decimal long multiplier: collects two operands digit by digit, sums the
// digit products column by column with carry, and streams the product MSD
// first.
//
//  channel | dir | tdata            | tuser          | tlast
//  --------+-----+------------------+----------------+------------------
//  s_*     | in  | [3:0] digit      | operation      | last_digit
//  m_*     | out | [3:0] prod digit | too_long       | last product digit
//
// Operand digits are taken only in the load phase. Then every column runs
// setup, one issue per digit pair through the single digit multiplier and
// accumulator, a drain and a split; a final carry column only setup and
// split. Each product digit is read from the result memory and held until
// m_tready. No input is taken until the last product digit is taken. Reset
// is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_schoolbook_multiplier_unit #(
	parameter int MAX_DIGITS = dsm_pkg::MAX_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [3:0] digit, [7:4] zero
	input  logic       s_tuser,   // [0] operation
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [3:0] product_digit, [7:4] zero
	output logic       m_tuser,   // [0] too_long
	output logic       m_tlast
);

	localparam int LW = $clog2(MAX_DIGITS + 1);
	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int RW = $clog2(2 * MAX_DIGITS);
	localparam int DW = dsm_pkg::DIGIT_W;

	dsm_pkg::dsm_ctrl_t ctrl;

	logic [LW-1:0] len_a_q, len_b_q;
	logic          done_a_q, done_b_q, overflow_q;
	logic [DW-1:0] digit_q;
	logic          last_q;

	logic          accept, sel_b, sel_done, sel_room;
	logic          we_a, we_b, start;
	logic [LW-1:0] sel_len;
	logic [DW-1:0] in_digit;
	logic          done_a_d, done_b_d;

	logic [AW-1:0] a_raddr, b_raddr;
	logic [DW-1:0] a_rdata, b_rdata;
	logic [RW-1:0] res_waddr, res_raddr;
	logic [DW-1:0] res_rdata, rem_digit;
	logic          carry_nz, pipe_busy, out_last;

	// operand loading
	always_comb begin
		accept   = s_tvalid && s_tready;
		sel_b    = (dsm_pkg::dsm_op_t'(s_tuser) == dsm_pkg::OP_SECOND);
		sel_done = sel_b ? done_b_q : done_a_q;
		sel_len  = sel_b ? len_b_q : len_a_q;
		sel_room = (sel_len < LW'(MAX_DIGITS));
		in_digit = dsm_pkg::digit_sat(s_tdata[DW-1:0]);
		we_a     = accept && !sel_b && !done_a_q && sel_room;
		we_b     = accept && sel_b && !done_b_q && sel_room;
		done_a_d = done_a_q || (accept && !sel_b && s_tlast);
		done_b_d = done_b_q || (accept && sel_b && s_tlast);
		start    = accept && !sel_done && done_a_d && done_b_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q    <= '0;
			len_b_q    <= '0;
			done_a_q   <= 1'b0;
			done_b_q   <= 1'b0;
			overflow_q <= 1'b0;
		end else if (ctrl.clear) begin
			len_a_q    <= '0;
			len_b_q    <= '0;
			done_a_q   <= 1'b0;
			done_b_q   <= 1'b0;
			overflow_q <= 1'b0;
		end else if (accept && !sel_done) begin
			if (we_a) len_a_q <= len_a_q + LW'(1);
			if (we_b) len_b_q <= len_b_q + LW'(1);
			if (!sel_room) overflow_q <= 1'b1;
			done_a_q <= done_a_d;
			done_b_q <= done_b_d;
		end
	end

	// operand stores
	dsm_digit_mem #(.DEPTH(MAX_DIGITS), .AW(AW)) u_mem_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (len_a_q[AW-1:0]),
		.wdata (in_digit),
		.re    (ctrl.issue),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	dsm_digit_mem #(.DEPTH(MAX_DIGITS), .AW(AW)) u_mem_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (len_b_q[AW-1:0]),
		.wdata (in_digit),
		.re    (ctrl.issue),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// product digits, least significant column at address zero
	dsm_digit_mem #(.DEPTH(2 * MAX_DIGITS), .AW(RW)) u_mem_res (
		.clk   (clk),
		.we    (ctrl.split),
		.waddr (res_waddr),
		.wdata (rem_digit),
		.re    (ctrl.res_rd),
		.raddr (res_raddr),
		.rdata (res_rdata)
	);

	dsm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.a_digit   (a_rdata),
		.b_digit   (b_rdata),
		.carry_nz  (carry_nz),
		.pipe_busy (pipe_busy),
		.rem_digit (rem_digit)
	);

	dsm_seq #(.MAX_DIGITS(MAX_DIGITS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.len_a     (len_a_q),
		.len_b     (len_b_q),
		.carry_nz  (carry_nz),
		.pipe_busy (pipe_busy),
		.out_ready (m_tready),
		.ctrl      (ctrl),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr),
		.res_waddr (res_waddr),
		.res_raddr (res_raddr),
		.out_last  (out_last)
	);

	// output register
	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			digit_q <= res_rdata;
			last_q  <= out_last;
		end
	end

	assign s_tready = ctrl.load_ready;
	assign m_tvalid = ctrl.out_valid;
	assign m_tdata  = {(8 - DW)'(0), digit_q};
	assign m_tuser  = overflow_q;
	assign m_tlast  = last_q;

endmodule
